FILE: hdl/pink_noise_generator_defines.svh
// Assertion macros shared by the pink noise generator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef PINK_NOISE_GENERATOR_DEFINES_SVH
`define PINK_NOISE_GENERATOR_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PNG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define PNG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/png_pkg.sv
// Types and constants for the pink noise generator.
// No dependencies; imported by every module of the block.
package png_pkg;

    localparam int GEN_W     = 32;
    localparam int WHITE_W   = 24;
    localparam int WHITE_LSB = 8;
    localparam int SUM_W     = 27;
    localparam int ROW_OUT_W = 3;

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    localparam logic [GEN_W-1:0] SEED_RESET = 32'd2463534242;

    typedef logic [GEN_W-1:0]            t_gen;
    typedef logic signed [WHITE_W-1:0]   t_white;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic [ROW_OUT_W-1:0]        t_row_out;

    typedef struct packed {
        t_sum     pink_sum;
        t_row_out updated_row;
    } t_row_result;

endpackage

FILE: hdl/png_gen.sv
// Xorshift white sample source with seed load.
// Depends on png_pkg.
module png_gen
    import png_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_gen   i_seed,
    input  logic   i_step,
    output t_white o_white
);

    t_gen r_word;
    t_gen n_word;
    t_gen x1;
    t_gen x2;

    always_comb begin
        x1     = r_word ^ (r_word << SHIFT_A);
        x2     = x1 ^ (x1 >> SHIFT_B);
        n_word = x2 ^ (x2 << SHIFT_C);
    end

    assign o_white = t_white'(n_word[WHITE_LSB +: WHITE_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= SEED_RESET;
        end else if (i_load) begin
            r_word <= i_seed;
        end else if (i_step) begin
            r_word <= n_word;
        end
    end

endmodule

FILE: hdl/png_rows.sv
// Tick counter, row select, row registers and running sum.
// Depends on png_pkg.
module png_rows
    import png_pkg::*;
#(
    parameter int ROW_COUNT = 5
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_white      i_white,
    output t_row_result o_result
);

    localparam int TICK_BITS = ROW_COUNT - 1;
    localparam int ROW_BITS  = $clog2(ROW_COUNT);

    logic [TICK_BITS-1:0] r_tick_count;
    logic [TICK_BITS-1:0] n_tick_count;
    t_white               r_rows [ROW_COUNT];
    t_sum                 r_total;
    t_sum                 n_total;
    logic [ROW_BITS-1:0]  sel;

    always_comb begin
        n_tick_count = r_tick_count + TICK_BITS'(1);
        sel          = ROW_BITS'(ROW_COUNT - 1);
        for (int i = TICK_BITS - 1; i >= 0; i--) begin
            if (n_tick_count[i]) begin
                sel = ROW_BITS'(i);
            end
        end
        n_total = r_total - t_sum'(r_rows[sel]) + t_sum'(i_white);
    end

    assign o_result.pink_sum    = n_total;
    assign o_result.updated_row = t_row_out'(sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_total      <= '0;
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_rows[i] <= '0;
            end
        end else if (i_step) begin
            r_tick_count <= n_tick_count;
            r_total      <= n_total;
            r_rows[sel]  <= i_white;
        end
    end

endmodule

FILE: hdl/pink_noise_generator.sv
// Pink noise generator top level: input register, row update, result register.
// Depends on png_pkg, png_gen and png_rows.
//
//  channel   valid     ready     payload
//  input     i_valid   o_ready   i_tick
//  output    o_valid   i_ready   o_pink_sum, o_updated_row
//  config    i_cfg_wr_en  -      i_cfg_wr_data (seed)
//
// One item per cycle sustained while results are taken; a tick item's result passes from
// the input register through the xorshift, row select and sum update into the result
// register, which drives o_valid.
// Synchronous active-low reset clears rows, sum and counter and loads the default seed.
// While a result waits, zero ticks still pass; a tick item stays in the input register
// and o_ready drops until the result is taken. A zero tick passes with no result.
module pink_noise_generator
    import png_pkg::*;
#(
    parameter int ROW_COUNT = 5
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  logic     i_tick,
    output logic     o_valid,
    input  logic     i_ready,
    output t_sum     o_pink_sum,
    output t_row_out o_updated_row,
    input  logic     i_cfg_wr_en,
    input  t_gen     i_cfg_wr_data
);

    logic        r_in_valid;
    logic        r_in_tick;
    logic        r_out_valid;
    t_sum        r_pink_sum;
    t_row_out    r_updated_row;
    logic        out_free;
    logic        advance;
    logic        step;
    t_white      white;
    t_row_result result;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!r_in_tick || out_free);
    assign step     = r_in_valid && r_in_tick && out_free;
    assign o_ready  = !r_in_valid || advance;

    png_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cfg_wr_en),
        .i_seed  (i_cfg_wr_data),
        .i_step  (step),
        .o_white (white)
    );

    png_rows #(
        .ROW_COUNT (ROW_COUNT)
    ) u_rows (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_white  (white),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_tick <= i_tick;
        end
        if (step) begin
            r_pink_sum    <= result.pink_sum;
            r_updated_row <= result.updated_row;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pink_sum    = r_pink_sum;
    assign o_updated_row = r_updated_row;

endmodule

FILE: hdl/png_checker.sv
// Port-level checker for the pink noise generator, bound to the top level.
// Depends on png_pkg and pink_noise_generator_defines.svh.
`include "pink_noise_generator_defines.svh"

module png_checker
    import png_pkg::*;
#(
    parameter int ROW_COUNT = 5
)
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_ready,
    input logic     o_valid,
    input logic     i_ready,
    input t_sum     o_pink_sum,
    input t_row_out o_updated_row
);

    logic r_seen;
    logic r_last_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_zero <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_seen      <= 1'b1;
            r_last_zero <= (o_updated_row == '0);
        end
    end

    `PNG_ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_pink_sum) && $stable(o_updated_row),
        "result changed while stalled")
    `PNG_ASSERT_SAME(a_ready_low, !o_ready, o_valid && !i_ready,
        "input held off without a stalled result")
    `PNG_ASSERT_SAME(a_row_range, o_valid,
        (ROW_COUNT > 8) || (int'(o_updated_row) < ROW_COUNT),
        "row index out of range")
    `PNG_ASSERT_SAME(a_row_alternate, o_valid && i_ready && r_seen,
        (o_updated_row == '0) != r_last_zero,
        "row zero not updated on every other item")

endmodule

bind pink_noise_generator png_checker #(.ROW_COUNT(ROW_COUNT)) u_png_checker (.*);

FILE: test/pink_noise_generator_tb.sv
// Self-checking testbench for pink_noise_generator: predicts every running sum and row
// index, under random idling, receiver stalls and seed changes. Depends on png_pkg.
`timescale 1ns / 100ps

module pink_noise_generator_tb;
    import png_pkg::*;

    localparam int ROW_COUNT   = 5;
    localparam int SETTLE      = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic     i_clk;
    logic     i_rst_n       = 1'b0;
    logic     i_valid       = 1'b0;
    logic     i_tick        = 1'b0;
    logic     i_ready       = 1'b0;
    logic     i_cfg_wr_en   = 1'b0;
    t_gen     i_cfg_wr_data = '0;
    logic     o_ready;
    logic     o_valid;
    t_sum     o_pink_sum;
    t_row_out o_updated_row;

    pink_noise_generator #(.ROW_COUNT(ROW_COUNT)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_tick        (i_tick),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pink_sum    (o_pink_sum),
        .o_updated_row (o_updated_row),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    t_gen                 gen_word;
    logic [ROW_COUNT-2:0] tick_count;
    t_white               row_vals [ROW_COUNT];
    t_sum                 row_total;
    t_row_result          pending_pink [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  ticks_taken    = 0;
    int  idle_taken     = 0;
    int  sums_checked   = 0;
    int  seed_loads     = 0;
    int  mismatches     = 0;
    int  cycles         = 0;
    bit  hold_active    = 1'b0;
    event hold_go;

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d sums pending", cycles, pending_pink.size());
            $display("** pink_noise_generator: FAILED **");
            $finish;
        end
    end

    always begin
        @(hold_go);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_row_result step_pink_rows();
        t_gen        x;
        t_white      white;
        t_sum        old_v;
        t_sum        new_v;
        int          sel;
        t_row_result r;
        x = gen_word;
        x ^= x << SHIFT_A;
        x ^= x >> SHIFT_B;
        x ^= x << SHIFT_C;
        gen_word = x;
        white = x[WHITE_LSB +: WHITE_W];
        tick_count = tick_count + 1'b1;
        sel = 0;
        while (sel < ROW_COUNT - 1 && tick_count[sel] == 1'b0)
            sel++;
        old_v = row_vals[sel];
        new_v = white;
        row_vals[sel] = white;
        row_total = row_total - old_v + new_v;
        r.pink_sum    = row_total;
        r.updated_row = t_row_out'(sel);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_row_result want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected sum=%0d row=%0d, got sum=%0d row=%0d", $time, what,
                     want.pink_sum, want.updated_row, o_pink_sum, o_updated_row);
    endtask

    always @(posedge i_clk) begin : score
        t_row_result want;
        if (!i_rst_n) begin
            gen_word   = SEED_RESET;
            tick_count = '0;
            row_total  = '0;
            for (int i = 0; i < ROW_COUNT; i++)
                row_vals[i] = '0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_pink.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected sum", want);
                end else begin
                    want = pending_pink.pop_front();
                    sums_checked++;
                    if (o_pink_sum !== want.pink_sum || o_updated_row !== want.updated_row)
                        report_mismatch("wrong sum", want);
                end
            end
            if (i_cfg_wr_en) begin
                gen_word = i_cfg_wr_data;
                seed_loads++;
            end
            if (i_valid && o_ready) begin
                if (i_tick) begin
                    pending_pink.push_back(step_pink_rows());
                    ticks_taken++;
                end else begin
                    idle_taken++;
                end
            end
        end
    end

    task automatic send_tick(input logic tick_bit);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_tick  <= tick_bit;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_pink.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_seed(input t_gen seed);
        settle_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= seed;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_directed_ticks();
        for (int n = 0; n < 18; n++)
            send_tick((n % 7) != 3);
    endtask

    task automatic test_seed_extremes();
        t_gen seeds [3];
        seeds = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
        foreach (seeds[k]) begin
            write_seed(seeds[k]);
            send_tick(1'b1);
            send_tick(1'b1);
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        int   sent;
        logic tick_bit;
        write_seed($urandom);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count) begin
            tick_bit = ($urandom_range(15) != 0);
            send_tick(tick_bit);
            if (tick_bit)
                sent++;
        end
        settle_block();
    endtask

    task automatic test_backpressure();
        write_seed(SEED_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        repeat (40)
            send_tick(1'b1);
        settle_block();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_ticks();
        test_seed_extremes();
        test_random_phase(0, 0, 230);
        test_random_phase(53, 0, 230);
        test_random_phase(0, 53, 230);
        test_random_phase(30, 30, 230);
        test_backpressure();

        settle_block();
        repeat (2 * SETTLE) @(negedge i_clk);

        $display("%0d ticks and %0d idle items sent, %0d sums checked, %0d seed loads",
                 ticks_taken, idle_taken, sums_checked, seed_loads);
        $display("idling phases, long receiver hold-off, zero and all-ones seeds; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_pink.size() == 0)
            $display("** pink_noise_generator: PASSED **");
        else
            $display("** pink_noise_generator: FAILED **");
        $finish;
    end

endmodule
